@@ rtl/graph_kcore_decomposition_core_assert.svh @@
// Assertion macros shared by the k-core decomposition RTL
`ifndef GRAPH_KCORE_DECOMPOSITION_CORE_ASSERT_SVH
`define GRAPH_KCORE_DECOMPOSITION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KCD_ASSERT_IMP(label, en, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
        else $error("kcd assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define KCD_ASSERT_NEXT(label, en, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
        else $error("kcd assertion failed");

`endif

@@ rtl/kcd_pkg.sv @@
// Shared constants, codes and types for the k-core decomposition block
package kcd_pkg;

    localparam int MAX_NODES_DEF    = 1024;
    localparam int MAX_EDGES_DEF    = 8192;
    localparam int OPCODE_W         = 2;
    localparam int NODE_ID_W        = 10;
    localparam int STATUS_W         = 2;
    localparam int NODE_COUNT_RESET = 1023;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ORDER    = 2'd2,
        STAT_BAD_NODE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FILL,
        S_QRY,
        S_EMIT,
        S_DG_TOP,
        S_NR_A,
        S_NR_B,
        S_NR_C,
        S_WK_A,
        S_WK_B,
        S_WK_C,
        S_WK_D,
        S_WK_E,
        S_WK_F,
        S_NODE_END,
        S_BCLR,
        S_BC_TOP,
        S_BC_B,
        S_BC_C,
        S_BP_A,
        S_BP_B,
        S_PC_TOP,
        S_PC_B,
        S_PC_C,
        S_SH_TOP,
        S_SH_B,
        S_PL_TOP,
        S_PL_B,
        S_PL_C,
        S_MX_TOP,
        S_MX_B
    } state_t;

endpackage

@@ rtl/kcd_stream_if.sv @@
// Request and response stream interfaces of the k-core decomposition block
interface kcd_req_if;
    import kcd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [NODE_ID_W-1:0] source_node;
    logic [NODE_ID_W-1:0] target_node;
    modport source (output valid, opcode, source_node, target_node, input ready);
    modport sink (input valid, opcode, source_node, target_node, output ready);
endinterface

interface kcd_rsp_if;
    import kcd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [NODE_ID_W-1:0] core_value;
    modport source (output valid, status, core_value, input ready);
    modport sink (input valid, status, core_value, output ready);
endinterface

@@ rtl/kcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module kcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/graph_kcore_decomposition_core.sv @@
// Load stores the edge and then fills the range-start entries; query reads the kept core and emits it.
// Compute counts each node's stored edges for degrees, runs the bin sort,
// then peels node by node over their edges, then scans all nodes for the maximum.
// One item is worked at a time; the edge store and node RAM ports set the pace.
// Reset (rst_n, async low) empties the edge store, clears errors and kept cores,
// and sets node_count to 1023; no memory clearing pass is needed.
`include "graph_kcore_decomposition_core_assert.svh"

module graph_kcore_decomposition_core #(
    parameter int MAX_NODES = kcd_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = kcd_pkg::MAX_EDGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [kcd_pkg::NODE_ID_W-1:0] cfg_data,
    kcd_req_if.sink                       req,
    kcd_rsp_if.source                     rsp
);
    import kcd_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int VW  = NW + 1;
    localparam int BW  = NW + 1;
    localparam int CW  = (NW > NODE_ID_W) ? NW : NODE_ID_W;

    // Memory ports
    logic                 et_we;
    logic [EW-1:0]        et_waddr, et_raddr;
    logic [NODE_ID_W-1:0] et_wdata, et_rdata;
    logic                 rs_we;
    logic [NW-1:0]        rs_waddr, rs_raddr;
    logic [ECW-1:0]       rs_wdata, rs_rdata;
    logic                 deg_we;
    logic [NW-1:0]        deg_waddr, deg_raddr, deg_wdata, deg_rdata;
    logic                 vert_we;
    logic [NW-1:0]        vert_waddr, vert_raddr, vert_wdata, vert_rdata;
    logic                 pos_we;
    logic [NW-1:0]        pos_waddr, pos_raddr, pos_wdata, pos_rdata;
    logic                 bin_we;
    logic [NW-1:0]        bin_waddr, bin_raddr;
    logic [BW-1:0]        bin_wdata, bin_rdata;

    // Control registers
    state_t               state_reg, state_next;
    logic [ECW-1:0]       ec_reg, ec_next;
    logic [NW-1:0]        ls_reg, ls_next, lt_reg, lt_next;
    logic [STATUS_W-1:0]  err_reg, err_next;
    logic [NODE_ID_W-1:0] node_count_reg, node_count_next;
    logic [NW-1:0]        hiw_reg, hiw_next;
    logic                 out_valid_reg, out_valid_next;

    // Work registers
    logic [VW-1:0]        v_reg, v_next, fill_v_reg, fill_v_next;
    logic [NW-1:0]        fill_end_reg, fill_end_next;
    logic [ECW-1:0]       fill_val_reg, fill_val_next;
    logic [NW-1:0]        d_reg, d_next, cur_reg, cur_next, cnt_reg, cnt_next;
    logic [NW-1:0]        md_reg, md_next, best_reg, best_next, dv_reg, dv_next;
    logic [NW-1:0]        u_reg, u_next, du_reg, du_next, pu_reg, pu_next;
    logic [NW-1:0]        pw_reg, pw_next;
    logic [ECW-1:0]       j_reg, j_next, hi_reg, hi_next;
    logic [BW-1:0]        start_reg, start_next;
    logic                 peel_reg, peel_next;
    logic [STATUS_W-1:0]  res_stat_reg, res_stat_next, out_stat_reg, out_stat_next;
    logic [NW-1:0]        res_val_reg, res_val_next, out_val_reg, out_val_next;

    // Decoded request and limits
    logic [CW-1:0]        n_cw, s_cw, t_cw, u_cw, cnt_cw, out_cw;
    logic [NW-1:0]        n_nw, s_nw, t_nw;
    logic [VW-1:0]        n_vw, fill_start;
    logic                 accept, bad_node, out_order, store_full, store_ok, u_ok;

    kcd_ram #(.WIDTH(NODE_ID_W), .DEPTH(MAX_EDGES)) u_et (
        .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
        .raddr(et_raddr), .rdata(et_rdata));
    kcd_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_rs (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata));
    kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata));
    kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_vert (
        .clk(clk), .we(vert_we), .waddr(vert_waddr), .wdata(vert_wdata),
        .raddr(vert_raddr), .rdata(vert_rdata));
    kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata));
    kcd_ram #(.WIDTH(BW), .DEPTH(MAX_NODES)) u_bin (
        .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
        .raddr(bin_raddr), .rdata(bin_rdata));

    // Clamp node_count to the node store and decode the request beat
    assign n_cw   = (CW'(node_count_reg) > CW'(MAX_NODES - 1)) ? CW'(MAX_NODES - 1)
                                                              : CW'(node_count_reg);
    assign n_nw   = n_cw[NW-1:0];
    assign n_vw   = {1'b0, n_nw};
    assign s_cw   = CW'(req.source_node);
    assign t_cw   = CW'(req.target_node);
    assign s_nw   = s_cw[NW-1:0];
    assign t_nw   = t_cw[NW-1:0];
    assign u_cw   = CW'(et_rdata);
    assign cnt_cw = CW'(cnt_reg);
    assign out_cw = CW'(out_val_reg);
    assign u_ok   = (u_cw != '0) && (u_cw <= n_cw);

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign bad_node   = (s_cw == '0) || (s_cw > n_cw) || (t_cw == '0) || (t_cw > n_cw);
    assign out_order  = (ec_reg != '0) && ({s_nw, t_nw} <= {ls_reg, lt_reg});
    assign store_full = (ec_reg == ECW'(MAX_EDGES));
    assign store_ok   = accept && (req.opcode == OP_LOAD) && !bad_node && (s_nw != t_nw)
                        && !out_order && !store_full;
    assign fill_start = (ec_reg == '0) ? VW'(1) : ({1'b0, ls_reg} + 1'b1);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_stat_reg;
    assign rsp.core_value = out_cw[NODE_ID_W-1:0];

    // Next state, memory control and datapath
    always_comb
    begin
        state_next      = state_reg;
        ec_next         = ec_reg;
        ls_next         = ls_reg;
        lt_next         = lt_reg;
        err_next        = err_reg;
        node_count_next = cfg_write ? cfg_data : node_count_reg;
        hiw_next        = hiw_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_stat_next   = out_stat_reg;
        out_val_next    = out_val_reg;
        v_next          = v_reg;
        fill_v_next     = fill_v_reg;
        fill_end_next   = fill_end_reg;
        fill_val_next   = fill_val_reg;
        d_next          = d_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        md_next         = md_reg;
        best_next       = best_reg;
        dv_next         = dv_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        pu_next         = pu_reg;
        pw_next         = pw_reg;
        j_next          = j_reg;
        hi_next         = hi_reg;
        start_next      = start_reg;
        peel_next       = peel_reg;
        res_stat_next   = res_stat_reg;
        res_val_next    = res_val_reg;
        et_we = 1'b0;   et_waddr = '0;   et_wdata = '0;   et_raddr = '0;
        rs_we = 1'b0;   rs_waddr = '0;   rs_wdata = '0;   rs_raddr = '0;
        deg_we = 1'b0;  deg_waddr = '0;  deg_wdata = '0;  deg_raddr = '0;
        vert_we = 1'b0; vert_waddr = '0; vert_wdata = '0; vert_raddr = '0;
        pos_we = 1'b0;  pos_waddr = '0;  pos_wdata = '0;  pos_raddr = '0;
        bin_we = 1'b0;  bin_waddr = '0;  bin_wdata = '0;  bin_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.opcode)
                        OP_LOAD:
                        begin
                            // Check, store the target and open the fill of range starts
                            if (bad_node)
                            begin
                                if (err_reg == STAT_OK) err_next = STAT_BAD_NODE;
                            end
                            else if (s_nw == t_nw)
                            begin
                                err_next = err_reg;
                            end
                            else if (out_order)
                            begin
                                if (err_reg == STAT_OK) err_next = STAT_ORDER;
                            end
                            else if (store_full)
                            begin
                                if (err_reg == STAT_OK) err_next = STAT_FULL;
                            end
                            else
                            begin
                                et_we         = 1'b1;
                                et_waddr      = ec_reg[EW-1:0];
                                et_wdata      = req.target_node;
                                ec_next       = ec_reg + 1'b1;
                                ls_next       = s_nw;
                                lt_next       = t_nw;
                                fill_v_next   = fill_start;
                                fill_end_next = s_nw;
                                fill_val_next = ec_reg;
                                if (fill_start <= {1'b0, s_nw}) state_next = S_FILL;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            v_next     = VW'(1);
                            md_next    = '0;
                            peel_next  = 1'b0;
                            state_next = S_DG_TOP;
                        end
                        OP_QUERY:
                        begin
                            res_val_next = '0;
                            if ((s_cw == '0) || (s_cw > n_cw))
                            begin
                                res_stat_next = STAT_BAD_NODE;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                res_stat_next = STAT_OK;
                                if (s_nw <= hiw_reg)
                                begin
                                    deg_raddr  = s_nw;
                                    state_next = S_QRY;
                                end
                                else
                                begin
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                rs_we    = 1'b1;
                rs_waddr = fill_v_reg[NW-1:0];
                rs_wdata = fill_val_reg;
                fill_v_next = fill_v_reg + 1'b1;
                if (fill_v_reg[NW-1:0] == fill_end_reg) state_next = S_IDLE;
            end
            S_QRY:
            begin
                res_val_next = deg_rdata;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_val_next   = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            S_DG_TOP:
            begin
                if (v_reg > n_vw)
                begin
                    d_next     = '0;
                    state_next = S_BCLR;
                end
                else
                begin
                    cur_next   = v_reg[NW-1:0];
                    cnt_next   = '0;
                    state_next = S_NR_A;
                end
            end
            S_NR_A:
            begin
                rs_raddr   = cur_reg;
                state_next = S_NR_B;
            end
            S_NR_B:
            begin
                // Resolve the end of this node's edge range
                if ((ec_reg == '0) || (cur_reg > ls_reg))
                begin
                    state_next = S_NODE_END;
                end
                else if (cur_reg == ls_reg)
                begin
                    hi_next    = ec_reg;
                    j_next     = (rs_rdata > ec_reg) ? ec_reg : rs_rdata;
                    state_next = S_WK_A;
                end
                else
                begin
                    j_next     = rs_rdata;
                    rs_raddr   = cur_reg + 1'b1;
                    state_next = S_NR_C;
                end
            end
            S_NR_C:
            begin
                hi_next    = (rs_rdata > ec_reg) ? ec_reg : rs_rdata;
                j_next     = (j_reg > hi_next) ? hi_next : j_reg;
                state_next = S_WK_A;
            end
            S_WK_A:
            begin
                if (j_reg == hi_reg)
                begin
                    state_next = S_NODE_END;
                end
                else
                begin
                    et_raddr   = j_reg[EW-1:0];
                    j_next     = j_reg + 1'b1;
                    state_next = S_WK_B;
                end
            end
            S_WK_B:
            begin
                // Drop targets outside the active node range
                state_next = S_WK_A;
                if (u_ok)
                begin
                    if (!peel_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        u_next     = u_cw[NW-1:0];
                        deg_raddr  = u_cw[NW-1:0];
                        state_next = S_WK_C;
                    end
                end
            end
            S_WK_C:
            begin
                du_next = deg_rdata;
                if (deg_rdata > dv_reg)
                begin
                    pos_raddr  = u_reg;
                    bin_raddr  = deg_rdata;
                    state_next = S_WK_D;
                end
                else
                begin
                    state_next = S_WK_A;
                end
            end
            S_WK_D:
            begin
                pu_next    = pos_rdata;
                pw_next    = bin_rdata[NW-1:0];
                vert_raddr = bin_rdata[NW-1:0];
                state_next = S_WK_E;
            end
            S_WK_E:
            begin
                // Move u to the front of its bin and lower its degree
                bin_we    = 1'b1;
                bin_waddr = du_reg;
                bin_wdata = {1'b0, pw_reg} + 1'b1;
                deg_we    = 1'b1;
                deg_waddr = u_reg;
                deg_wdata = du_reg - 1'b1;
                d_next    = vert_rdata;
                if (u_reg != vert_rdata)
                begin
                    pos_we     = 1'b1;
                    pos_waddr  = u_reg;
                    pos_wdata  = pw_reg;
                    vert_we    = 1'b1;
                    vert_waddr = pu_reg;
                    vert_wdata = vert_rdata;
                    state_next = S_WK_F;
                end
                else
                begin
                    state_next = S_WK_A;
                end
            end
            S_WK_F:
            begin
                pos_we     = 1'b1;
                pos_waddr  = d_reg;
                pos_wdata  = pu_reg;
                vert_we    = 1'b1;
                vert_waddr = pw_reg;
                vert_wdata = u_reg;
                state_next = S_WK_A;
            end
            S_NODE_END:
            begin
                v_next = v_reg + 1'b1;
                if (!peel_reg)
                begin
                    deg_we     = 1'b1;
                    deg_waddr  = cur_reg;
                    deg_wdata  = cnt_reg;
                    md_next    = (cnt_cw > CW'(md_reg)) ? cnt_reg : md_reg;
                    state_next = S_DG_TOP;
                end
                else
                begin
                    state_next = S_PL_TOP;
                end
            end
            S_BCLR:
            begin
                bin_we    = 1'b1;
                bin_waddr = d_reg;
                bin_wdata = '0;
                if (d_reg == md_reg)
                begin
                    v_next     = VW'(1);
                    state_next = S_BC_TOP;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                end
            end
            S_BC_TOP:
            begin
                if (v_reg > n_vw)
                begin
                    d_next     = '0;
                    start_next = BW'(1);
                    state_next = S_BP_A;
                end
                else
                begin
                    deg_raddr  = v_reg[NW-1:0];
                    state_next = S_BC_B;
                end
            end
            S_BC_B:
            begin
                du_next    = deg_rdata;
                bin_raddr  = deg_rdata;
                state_next = S_BC_C;
            end
            S_BC_C:
            begin
                bin_we     = 1'b1;
                bin_waddr  = du_reg;
                bin_wdata  = bin_rdata + 1'b1;
                v_next     = v_reg + 1'b1;
                state_next = S_BC_TOP;
            end
            S_BP_A:
            begin
                bin_raddr  = d_reg;
                state_next = S_BP_B;
            end
            S_BP_B:
            begin
                bin_we     = 1'b1;
                bin_waddr  = d_reg;
                bin_wdata  = start_reg;
                start_next = start_reg + bin_rdata;
                if (d_reg == md_reg)
                begin
                    v_next     = VW'(1);
                    state_next = S_PC_TOP;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = S_BP_A;
                end
            end
            S_PC_TOP:
            begin
                if (v_reg > n_vw)
                begin
                    d_next     = md_reg;
                    state_next = S_SH_TOP;
                end
                else
                begin
                    deg_raddr  = v_reg[NW-1:0];
                    state_next = S_PC_B;
                end
            end
            S_PC_B:
            begin
                du_next    = deg_rdata;
                bin_raddr  = deg_rdata;
                state_next = S_PC_C;
            end
            S_PC_C:
            begin
                // Place the node at its bin slot
                pos_we     = 1'b1;
                pos_waddr  = v_reg[NW-1:0];
                pos_wdata  = bin_rdata[NW-1:0];
                vert_we    = 1'b1;
                vert_waddr = bin_rdata[NW-1:0];
                vert_wdata = v_reg[NW-1:0];
                bin_we     = 1'b1;
                bin_waddr  = du_reg;
                bin_wdata  = bin_rdata + 1'b1;
                v_next     = v_reg + 1'b1;
                state_next = S_PC_TOP;
            end
            S_SH_TOP:
            begin
                if (d_reg == '0)
                begin
                    bin_we     = 1'b1;
                    bin_waddr  = '0;
                    bin_wdata  = BW'(1);
                    v_next     = VW'(1);
                    peel_next  = 1'b1;
                    state_next = S_PL_TOP;
                end
                else
                begin
                    bin_raddr  = d_reg - 1'b1;
                    state_next = S_SH_B;
                end
            end
            S_SH_B:
            begin
                bin_we     = 1'b1;
                bin_waddr  = d_reg;
                bin_wdata  = bin_rdata;
                d_next     = d_reg - 1'b1;
                state_next = S_SH_TOP;
            end
            S_PL_TOP:
            begin
                if (v_reg > n_vw)
                begin
                    v_next     = VW'(1);
                    best_next  = '0;
                    state_next = S_MX_TOP;
                end
                else
                begin
                    vert_raddr = v_reg[NW-1:0];
                    state_next = S_PL_B;
                end
            end
            S_PL_B:
            begin
                cur_next   = vert_rdata;
                deg_raddr  = vert_rdata;
                state_next = S_PL_C;
            end
            S_PL_C:
            begin
                dv_next    = deg_rdata;
                state_next = S_NR_A;
            end
            S_MX_TOP:
            begin
                if (v_reg > n_vw)
                begin
                    hiw_next      = (n_nw > hiw_reg) ? n_nw : hiw_reg;
                    res_stat_next = err_reg;
                    res_val_next  = best_reg;
                    state_next    = S_EMIT;
                end
                else
                begin
                    deg_raddr  = v_reg[NW-1:0];
                    state_next = S_MX_B;
                end
            end
            S_MX_B:
            begin
                best_next  = (deg_rdata > best_reg) ? deg_rdata : best_reg;
                v_next     = v_reg + 1'b1;
                state_next = S_MX_TOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ec_reg         <= '0;
            ls_reg         <= '0;
            lt_reg         <= '0;
            err_reg        <= STAT_OK;
            node_count_reg <= NODE_ID_W'(NODE_COUNT_RESET);
            hiw_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ec_reg         <= ec_next;
            ls_reg         <= ls_next;
            lt_reg         <= lt_next;
            err_reg        <= err_next;
            node_count_reg <= node_count_next;
            hiw_reg        <= hiw_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_stat_reg <= out_stat_next;
        out_val_reg  <= out_val_next;
        v_reg        <= v_next;
        fill_v_reg   <= fill_v_next;
        fill_end_reg <= fill_end_next;
        fill_val_reg <= fill_val_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        md_reg       <= md_next;
        best_reg     <= best_next;
        dv_reg       <= dv_next;
        u_reg        <= u_next;
        du_reg       <= du_next;
        pu_reg       <= pu_next;
        pw_reg       <= pw_next;
        j_reg        <= j_next;
        hi_reg       <= hi_next;
        start_reg    <= start_next;
        peel_reg     <= peel_next;
        res_stat_reg <= res_stat_next;
        res_val_reg  <= res_val_next;
    end

    // A stored edge bumps the count by exactly one
    `KCD_ASSERT_NEXT(a_load_count, store_ok, ec_reg == $past(ec_reg) + 1'b1)
    // A result leaving the sequencer lands in the output register
    `KCD_ASSERT_NEXT(a_emit_out, (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready),
        out_valid_reg && (state_reg == S_IDLE))
    // Compute starts the degree pass at node one
    `KCD_ASSERT_NEXT(a_compute_start, accept && (req.opcode == OP_COMPUTE),
        (state_reg == S_DG_TOP) && (v_reg == VW'(1)) && !peel_reg)
endmodule
